FILE: src/threshold_partial_insertion_sort_macros.svh
// Assertion helpers for the partial insertion sort checker.
`ifndef THRESHOLD_PARTIAL_INSERTION_SORT_MACROS_SVH
`define THRESHOLD_PARTIAL_INSERTION_SORT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TPIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tpis check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TPIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tpis check failed");

`endif

FILE: src/tpis_pkg.sv
package tpis_pkg;

  // One stored list entry
  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        payload;
  } item_t;

  // Input transfer
  typedef struct packed {
    logic signed [31:0] item_key;
    logic [31:0]        item_payload;
    logic               last_item;
  } in_t;

  // Result transfer
  typedef struct packed {
    logic signed [31:0] out_key;
    logic [31:0]        out_payload;
    logic               out_last;
  } out_t;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic first;    // first item of a list goes to cell 0
    logic ins;      // sorted insert into prefix, rotate tail queue
    logic app;      // append to back of tail queue
    logic emit_dn;  // prefix drains toward cell 0
    logic emit_up;  // tail drains toward the top cell
  } ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StEmitPre,
    StEmitTail
  } state_e;

  localparam logic [31:0] LimitReset = 32'h8000_0000;

endpackage

FILE: src/tpis_cell.sv
// One storage cell of the chain. Prefix lives in the low cells sorted
// descending; the unsorted tail is a queue in the high cells, front at the top.
module tpis_cell #(
  parameter int unsigned MaxItems = 64,
  parameter int unsigned Index    = 0,
  localparam int unsigned IdxW    = $clog2(MaxItems),
  localparam int unsigned CntW    = $clog2(MaxItems + 1)
) (
  input  logic              clk_i,
  input  tpis_pkg::ctrl_t   ctrl_i,
  input  logic [IdxW-1:0]   pe_i,
  input  logic [CntW-1:0]   tail_lo_i,
  input  tpis_pkg::item_t   entry_i,
  input  tpis_pkg::item_t   front_i,
  input  tpis_pkg::item_t   left_i,
  input  tpis_pkg::item_t   right_i,
  input  logic              lt_prev_i,
  output tpis_pkg::item_t   data_o,
  output logic              lt_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Index);

  tpis_pkg::item_t data_q, data_d;
  logic [CntW-1:0] ins_end;
  logic            lt_self;

  // Held key strictly below the incoming key: the incoming item goes ahead of it
  assign lt_o    = $signed(data_q.key) < $signed(entry_i.key);
  assign ins_end = CntW'(pe_i) + CntW'(1);
  // The free slot just past the prefix always yields to the insertion
  assign lt_self = (IdxC == ins_end) ? 1'b1 : lt_o;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.first && (IdxC == '0)) begin
      data_d = entry_i;
    end
    if (ctrl_i.ins) begin
      // prefix: shift right behind the insert point
      if (IdxC <= ins_end) begin
        data_d = lt_prev_i ? left_i : (lt_self ? entry_i : data_q);
      end
      // tail: front item rotates to the back of the queue
      if (IdxC >= tail_lo_i) begin
        data_d = (IdxC == tail_lo_i) ? front_i : left_i;
      end
    end
    if (ctrl_i.app && ((IdxC + CntW'(1)) == tail_lo_i)) begin
      data_d = entry_i;
    end
    if (ctrl_i.emit_dn && ((IdxC + CntW'(1)) < tail_lo_i)) begin
      data_d = right_i;
    end
    if (ctrl_i.emit_up) begin
      data_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/threshold_partial_insertion_sort.sv
// Items are taken while idle; a list of n items is emitted one result per
// cycle after its final item is taken, via the state and result registers.
// Throughput: one item per cycle while a list is collected (one insertion step
// through the cell chain), then emission of the n results with busy_o high.
// Reset: asynchronous, active low; clears the list, limit becomes the minimum.
// The receiver cannot stall: each result is on the ports for one cycle only.
module threshold_partial_insertion_sort #(
  parameter int unsigned MaxItems = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            start_i,
  input  tpis_pkg::in_t   in_item_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output tpis_pkg::out_t  result_o
);

  localparam int unsigned IdxW = $clog2(MaxItems);
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  tpis_pkg::state_e state_q, state_d;
  logic [31:0]      limit_q;
  logic [IdxW-1:0]  pe_q, pe_d;
  logic [IdxW-1:0]  tlen_q, tlen_d;
  logic             open_q, open_d;
  logic             res_valid_q, res_valid_d;
  tpis_pkg::item_t  res_item_q, res_item_d;
  logic             res_last_q, res_last_d;

  tpis_pkg::ctrl_t  ctrl;
  tpis_pkg::item_t  entry;
  tpis_pkg::item_t  cell_data [MaxItems];
  logic             cell_lt   [MaxItems];
  logic [CntW-1:0]  tail_lo;
  logic [CntW-1:0]  cnt_nx;
  logic             accept;
  logic             key_ge;
  logic             done;

  assign accept        = start_i && (state_q == tpis_pkg::StIdle);
  assign entry.key     = in_item_i.item_key;
  assign entry.payload = in_item_i.item_payload;
  assign key_ge        = $signed(in_item_i.item_key) >= $signed(limit_q);
  assign tail_lo       = CntW'(MaxItems) - CntW'(tlen_q);

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tpis_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Cell chain
  for (genvar g = 0; g < MaxItems; g++) begin : g_cell
    tpis_pkg::item_t left_w, right_w;
    logic            lt_prev_w;
    if (g == 0) begin : g_first
      assign left_w    = cell_data[0];
      assign lt_prev_w = 1'b0;
    end else begin : g_mid
      assign left_w    = cell_data[g-1];
      assign lt_prev_w = cell_lt[g-1];
    end
    if (g == MaxItems - 1) begin : g_top
      assign right_w = cell_data[g];
    end else begin : g_below
      assign right_w = cell_data[g+1];
    end
    tpis_cell #(
      .MaxItems (MaxItems),
      .Index    (g)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .pe_i      (pe_q),
      .tail_lo_i (tail_lo),
      .entry_i   (entry),
      .front_i   (cell_data[MaxItems-1]),
      .left_i    (left_w),
      .right_i   (right_w),
      .lt_prev_i (lt_prev_w),
      .data_o    (cell_data[g]),
      .lt_o      (cell_lt[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpis_pkg::StIdle: begin
        if (accept && done) state_d = tpis_pkg::StEmitPre;
      end
      tpis_pkg::StEmitPre: begin
        if (pe_q == '0) begin
          state_d = (tlen_q == '0) ? tpis_pkg::StIdle : tpis_pkg::StEmitTail;
        end
      end
      tpis_pkg::StEmitTail: begin
        if (tlen_q == IdxW'(1)) state_d = tpis_pkg::StIdle;
      end
      default: state_d = tpis_pkg::StIdle;
    endcase
  end

  // Outputs, chain control and list bookkeeping
  always_comb begin
    ctrl        = '0;
    pe_d        = pe_q;
    tlen_d      = tlen_q;
    open_d      = open_q;
    res_valid_d = 1'b0;
    res_item_d  = res_item_q;
    res_last_d  = 1'b0;
    cnt_nx      = '0;
    done        = 1'b0;
    busy_o      = 1'b1;
    case (state_q)
      tpis_pkg::StIdle: begin
        busy_o = 1'b0;
        if (accept) begin
          if (!open_q) begin
            ctrl.first = 1'b1;
            pe_d       = '0;
            tlen_d     = '0;
          end else if (key_ge) begin
            ctrl.ins = 1'b1;
            pe_d     = pe_q + IdxW'(1);
          end else begin
            ctrl.app = 1'b1;
            tlen_d   = tlen_q + IdxW'(1);
          end
          cnt_nx = CntW'(pe_d) + CntW'(1) + CntW'(tlen_d);
          done   = in_item_i.last_item || (cnt_nx == CntW'(MaxItems));
          open_d = !done;
        end
      end
      tpis_pkg::StEmitPre: begin
        ctrl.emit_dn = 1'b1;
        res_valid_d  = 1'b1;
        res_item_d   = cell_data[0];
        res_last_d   = (pe_q == '0) && (tlen_q == '0);
        if (pe_q != '0) pe_d = pe_q - IdxW'(1);
      end
      tpis_pkg::StEmitTail: begin
        ctrl.emit_up = 1'b1;
        res_valid_d  = 1'b1;
        res_item_d   = cell_data[MaxItems-1];
        res_last_d   = (tlen_q == IdxW'(1));
        tlen_d       = tlen_q - IdxW'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpis_pkg::StIdle;
      pe_q        <= '0;
      tlen_q      <= '0;
      open_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pe_q        <= pe_d;
      tlen_q      <= tlen_d;
      open_q      <= open_d;
      res_valid_q <= res_valid_d;
      res_last_q  <= res_last_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_item_q <= res_item_d;
  end

  assign result_valid_o       = res_valid_q;
  assign result_o.out_key     = res_item_q.key;
  assign result_o.out_payload = res_item_q.payload;
  assign result_o.out_last    = res_last_q;

endmodule

FILE: src/tpis_checker.sv
`include "threshold_partial_insertion_sort_macros.svh"

// Port-level checks on the sort block
module tpis_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input tpis_pkg::in_t   in_item_i,
  input logic            busy_o,
  input logic            result_valid_o,
  input tpis_pkg::out_t  result_o
);

  // final result of a list shows with the block already free
  `TPIS_ASSERT_IMP(a_last_frees, clk_i, rst_ni, result_valid_o && result_o.out_last, !busy_o)

  // a result only follows a busy cycle
  `TPIS_ASSERT_IMP(a_res_after_busy, clk_i, rst_ni, result_valid_o, $past(busy_o))

  // transfer of a final item starts emission
  `TPIS_ASSERT_NXT(a_last_busy, clk_i, rst_ni, start_i && !busy_o && in_item_i.last_item, busy_o)

  // every busy cycle yields a result in the next cycle
  `TPIS_ASSERT_NXT(a_busy_emits, clk_i, rst_ni, busy_o, result_valid_o)

endmodule

bind threshold_partial_insertion_sort tpis_checker u_tpis_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .in_item_i      (in_item_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
